@@ design/pita_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, character codes and the digit-to-ASCII function for the
// padded integer to ASCII formatter. No dependencies.
package pita_pkg;

    // counts of characters, digits and padding (up to 64, plus sign and prefix)
    localparam int CNT_W       = 7;
    localparam int DIG_W       = 6;
    localparam int ADDR_W      = 6;
    localparam int MAX_RESULTS = 64;

    localparam logic [7:0] RADIX_MIN  = 8'd2;
    localparam logic [7:0] RADIX_MAX  = 8'd36;
    localparam logic [7:0] RADIX_OCT  = 8'd8;
    localparam logic [7:0] RADIX_HEX  = 8'd16;
    localparam logic [DIG_W-1:0] DEC_DIGITS = 6'd10;
    // position of 'x'/'X' in the digit alphabet
    localparam logic [DIG_W-1:0] X_DIGIT    = 6'd33;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    typedef struct packed {
        logic              bad;
        logic [CNT_W-1:0]  pad_cnt;
        logic              pad_lead_space;
        logic              pad_zero;
        logic              pad_trail;
        logic              sign_en;
        logic [7:0]        sign_ch;
        logic [1:0]        pre_len;
        logic              lower;
        logic [CNT_W-1:0]  lz_cnt;
        logic [CNT_W-1:0]  dig_cnt;
    } pita_layout_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [DIG_W-1:0]  data;
    } pita_dig_wr_t;

    function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d, input logic lower);
        logic [7:0] base_ch;
        base_ch = lower ? CH_LOWER_A : CH_UPPER_A;
        if (d < DEC_DIGITS)
            return CH_ZERO + 8'(d);
        else
            return base_ch + 8'(d) - 8'(DEC_DIGITS);
    endfunction

endpackage

@@ design/pita_divider.sv @@
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on pita_pkg for the digit width.
module pita_divider
    import pita_pkg::*;
#(
    parameter int VALUE_BITS = 32
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [DIG_W-1:0]      divisor,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [DIG_W-1:0]      remainder,
    output logic                  done
);

    localparam int STEP_W = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] dvd_reg;
    logic [DIG_W-1:0]      div_reg;
    logic [DIG_W-1:0]      rem_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIG_W:0]        trial;
    logic                  ge;
    logic [DIG_W-1:0]      rem_next;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[VALUE_BITS-1]};
        ge       = trial >= {1'b0, div_reg};
        rem_next = ge ? DIG_W'(trial - {1'b0, div_reg}) : trial[DIG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(VALUE_BITS - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift in where the dividend bits shift out
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[VALUE_BITS-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign quotient  = dvd_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

@@ design/pita_emitter.sv @@
`timescale 1ns / 1ps
// Character sequencer: holds the digit store and walks the text segments (padding,
// sign, prefix, zeros, digits) one character per cycle unless stalled. Uses pita_pkg.
module pita_emitter
    import pita_pkg::*;
#(
    parameter int VALUE_BITS = 32
)(
    input  logic         clk,
    input  logic         rst_n,
    input  pita_dig_wr_t dig_wr,
    input  logic         start,
    input  pita_layout_t lay,
    output logic         idle,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   text_char,
    output logic         last,
    output logic         bad_base
);

    localparam int IDX_W = $clog2(VALUE_BITS);

    typedef enum logic [3:0] {
        E_IDLE, E_ERR, E_PADL, E_SIGN, E_PRE0, E_PREX, E_ZPAD, E_LZ, E_DIG, E_PADR
    } emit_state_t;

    emit_state_t       state_reg;
    pita_layout_t      lay_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  emit_cnt_reg;
    logic [IDX_W-1:0]  ptr_reg;
    logic [IDX_W-1:0]  ptr_next;
    logic [DIG_W-1:0]  rd_data_reg;
    logic              out_valid_reg;
    logic [7:0]        text_char_reg;
    logic              last_reg;
    logic              bad_reg;

    logic [DIG_W-1:0]  mem [VALUE_BITS];

    logic              fire;
    logic              final_char;
    emit_state_t       nxt_seg;
    emit_state_t       first_seg;
    logic [7:0]        ch;

    function automatic logic [CNT_W-1:0] seg_len(input emit_state_t s, input pita_layout_t l);
        logic [CNT_W-1:0] n;
        n = '0;
        unique case (s)
            E_ERR:   n = CNT_W'(1);
            E_PADL:  n = l.pad_lead_space ? l.pad_cnt : '0;
            E_SIGN:  n = CNT_W'(l.sign_en);
            E_PRE0:  n = CNT_W'(l.pre_len != 2'd0);
            E_PREX:  n = CNT_W'(l.pre_len == 2'd2);
            E_ZPAD:  n = l.pad_zero ? l.pad_cnt : '0;
            E_LZ:    n = l.lz_cnt;
            E_DIG:   n = l.dig_cnt;
            E_PADR:  n = l.pad_trail ? l.pad_cnt : '0;
            default: n = '0;
        endcase
        return n;
    endfunction

    // first non-empty text segment that follows s
    function automatic emit_state_t first_after(input emit_state_t s, input pita_layout_t l);
        emit_state_t r;
        r = E_IDLE;
        if (s < E_PADR && seg_len(E_PADR, l) != '0) r = E_PADR;
        if (s < E_DIG  && seg_len(E_DIG,  l) != '0) r = E_DIG;
        if (s < E_LZ   && seg_len(E_LZ,   l) != '0) r = E_LZ;
        if (s < E_ZPAD && seg_len(E_ZPAD, l) != '0) r = E_ZPAD;
        if (s < E_PREX && seg_len(E_PREX, l) != '0) r = E_PREX;
        if (s < E_PRE0 && seg_len(E_PRE0, l) != '0) r = E_PRE0;
        if (s < E_SIGN && seg_len(E_SIGN, l) != '0) r = E_SIGN;
        if (s < E_PADL && seg_len(E_PADL, l) != '0) r = E_PADL;
        return r;
    endfunction

    always_comb
    begin
        fire       = (state_reg != E_IDLE) && (!out_valid_reg || out_ready);
        nxt_seg    = first_after(state_reg, lay_reg);
        first_seg  = first_after(E_ERR, lay);
        final_char = (state_reg == E_ERR)
                   || (rem_reg == CNT_W'(1) && nxt_seg == E_IDLE)
                   || (emit_cnt_reg == CNT_W'(MAX_RESULTS - 1));

        unique case (state_reg) inside
            E_PADL, E_PADR:       ch = CH_SPACE;
            E_SIGN:               ch = lay_reg.sign_ch;
            E_PRE0, E_ZPAD, E_LZ: ch = CH_ZERO;
            E_PREX:               ch = digit_char(X_DIGIT, lay_reg.lower);
            E_DIG:                ch = digit_char(rd_data_reg, lay_reg.lower);
            default:              ch = CH_NUL;
        endcase

        if (start)
            ptr_next = IDX_W'(lay.dig_cnt - CNT_W'(1));
        else if (fire && state_reg == E_DIG)
            ptr_next = ptr_reg - 1'b1;
        else
            ptr_next = ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_IDLE;
            rem_reg       <= '0;
            emit_cnt_reg  <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            bad_reg       <= 1'b0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            if (start)
            begin
                emit_cnt_reg <= '0;
                if (lay.bad)
                begin
                    state_reg <= E_ERR;
                    rem_reg   <= CNT_W'(1);
                end
                else
                begin
                    state_reg <= first_seg;
                    rem_reg   <= seg_len(first_seg, lay);
                end
            end
            else if (fire)
            begin
                emit_cnt_reg <= emit_cnt_reg + 1'b1;
                if (final_char)
                    state_reg <= E_IDLE;
                else if (rem_reg == CNT_W'(1))
                begin
                    state_reg <= nxt_seg;
                    rem_reg   <= seg_len(nxt_seg, lay_reg);
                end
                else
                    rem_reg <= rem_reg - 1'b1;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
                last_reg      <= final_char;
                bad_reg       <= (state_reg == E_ERR);
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            lay_reg <= lay;
        if (fire)
            text_char_reg <= ch;
    end

    // digit store: one write port, registered read at the next pointer
    always_ff @(posedge clk)
    begin
        if (dig_wr.we)
            mem[dig_wr.addr[IDX_W-1:0]] <= dig_wr.data;
        rd_data_reg <= mem[ptr_next];
    end

    assign idle      = (state_reg == E_IDLE);
    assign out_valid = out_valid_reg;
    assign text_char = text_char_reg;
    assign last      = last_reg;
    assign bad_base  = bad_reg;

endmodule

@@ design/padded_integer_to_ascii.sv @@
`timescale 1ns / 1ps
// Top level of the printf-style integer formatter: input capture, digit
// extraction control and layout. Depends on pita_pkg, pita_divider, pita_emitter.
//
// Usage: one input transaction carries a value, a radix and format controls.
// The result is a run of output transactions, one ASCII character each, with
// last set on the final one. A radix outside 2..36 gives one transaction with
// text_char 0, last 1 and bad_base 1.
// Flow: digits are extracted least significant first by a bit-serial divider;
// each digit takes a start step, VALUE_BITS quotient bits and a write-back.
// After the last digit come the layout step and the emitter start, then one
// character per cycle while out_ready is high. A bad radix skips extraction and
// layout and goes straight to the emitter start for its single result.
// in_ready is high only while no extraction runs and the previous item's
// characters have all been placed in the output register, so items are
// processed one at a time. The output register holds its transaction while
// out_ready is low and the sequencer waits. Reset clears all control state;
// no clearing pass is needed.
module padded_integer_to_ascii
    import pita_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 32,
    parameter int MAX_WIDTH  = 64
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [7:0]            radix,
    input  logic [6:0]            min_width,
    input  logic [5:0]            min_digits,
    input  logic                  zero_pad,
    input  logic                  signed_mode,
    input  logic                  show_plus,
    input  logic                  space_sign,
    input  logic                  left_justify,
    input  logic                  alt_prefix,
    input  logic                  lower_case,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            text_char,
    output logic                  last,
    output logic                  bad_base
);

    typedef enum logic [2:0] {T_IDLE, T_START, T_DIV, T_LAYOUT, T_GO} top_state_t;

    top_state_t            state_reg;
    logic [VALUE_BITS-1:0] quot_reg;
    logic [DIG_W-1:0]      radix_reg;
    logic [CNT_W-1:0]      width_reg;
    logic [CNT_W-1:0]      prec_reg;
    logic [CNT_W-1:0]      dcnt_reg;
    logic                  left_reg;
    logic                  zp_reg;
    logic                  lower_reg;
    logic                  sign_en_reg;
    logic [7:0]            sign_ch_reg;
    logic [1:0]            pre_len_reg;
    pita_layout_t          layout_reg;

    logic                  accept;
    logic                  bad_in;
    logic                  neg_in;
    logic [VALUE_BITS-1:0] mag_in;
    logic [CNT_W-1:0]      width_sat;
    logic [CNT_W-1:0]      prec_sat;
    logic                  sign_en_in;
    logic [7:0]            sign_ch_in;
    logic [1:0]            pre_len_in;

    logic [CNT_W-1:0]      ndig;
    logic [CNT_W-1:0]      used;
    logic [CNT_W-1:0]      pad;
    logic [CNT_W-1:0]      dcnt_inc;
    pita_layout_t          layout_calc;
    pita_layout_t          layout_bad;

    logic                  div_start;
    logic [VALUE_BITS-1:0] div_quot;
    logic [DIG_W-1:0]      div_rem;
    logic                  div_done;
    pita_dig_wr_t          dig_wr;
    logic                  emit_idle;
    logic                  emit_start;

    always_comb
    begin
        accept     = in_valid && in_ready;
        bad_in     = (radix < RADIX_MIN) || (radix > RADIX_MAX);
        neg_in     = signed_mode && value[VALUE_BITS-1];
        mag_in     = neg_in ? (VALUE_BITS'(0) - value) : value;
        width_sat  = (min_width > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : min_width;
        prec_sat   = ({1'b0, min_digits} > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS)
                                                               : {1'b0, min_digits};
        sign_en_in = neg_in || (signed_mode && (show_plus || space_sign));
        if (neg_in)
            sign_ch_in = CH_MINUS;
        else if (show_plus)
            sign_ch_in = CH_PLUS;
        else
            sign_ch_in = CH_SPACE;
        if (!alt_prefix)
            pre_len_in = 2'd0;
        else if (radix == RADIX_HEX)
            pre_len_in = 2'd2;
        else if (radix == RADIX_OCT)
            pre_len_in = 2'd1;
        else
            pre_len_in = 2'd0;

        ndig     = (prec_reg > dcnt_reg) ? prec_reg : dcnt_reg;
        used     = CNT_W'(sign_en_reg) + CNT_W'(pre_len_reg) + ndig;
        pad      = (width_reg > used) ? (width_reg - used) : '0;
        dcnt_inc = dcnt_reg + 1'b1;

        layout_calc.bad            = 1'b0;
        layout_calc.pad_cnt        = pad;
        layout_calc.pad_lead_space = !left_reg && !zp_reg;
        layout_calc.pad_zero       = zp_reg;
        layout_calc.pad_trail      = left_reg;
        layout_calc.sign_en        = sign_en_reg;
        layout_calc.sign_ch        = sign_ch_reg;
        layout_calc.pre_len        = pre_len_reg;
        layout_calc.lower          = lower_reg;
        layout_calc.lz_cnt         = ndig - dcnt_reg;
        layout_calc.dig_cnt        = dcnt_reg;

        layout_bad     = '0;
        layout_bad.bad = 1'b1;

        div_start   = (state_reg == T_START);
        emit_start  = (state_reg == T_GO);
        dig_wr.we   = (state_reg == T_DIV) && div_done;
        dig_wr.addr = dcnt_reg[ADDR_W-1:0];
        dig_wr.data = div_rem;
    end

    assign in_ready = (state_reg == T_IDLE) && emit_idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            dcnt_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        dcnt_reg  <= '0;
                        state_reg <= bad_in ? T_GO : T_START;
                    end
                end
                T_START:
                    state_reg <= T_DIV;
                T_DIV:
                begin
                    if (div_done)
                    begin
                        dcnt_reg <= dcnt_inc;
                        if (div_quot != '0 && dcnt_inc < CNT_W'(VALUE_BITS))
                            state_reg <= T_START;
                        else
                            state_reg <= T_LAYOUT;
                    end
                end
                T_LAYOUT:
                    state_reg <= T_GO;
                T_GO:
                    state_reg <= T_IDLE;
                default:
                    state_reg <= T_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            quot_reg    <= mag_in;
            radix_reg   <= radix[DIG_W-1:0];
            width_reg   <= width_sat;
            prec_reg    <= prec_sat;
            left_reg    <= left_justify;
            zp_reg      <= zero_pad && !left_justify;
            lower_reg   <= lower_case;
            sign_en_reg <= sign_en_in;
            sign_ch_reg <= sign_ch_in;
            pre_len_reg <= pre_len_in;
            layout_reg  <= layout_bad;
        end
        else if (state_reg == T_DIV && div_done)
            quot_reg <= div_quot;
        else if (state_reg == T_LAYOUT)
            layout_reg <= layout_calc;
    end

    pita_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (quot_reg),
        .divisor   (radix_reg),
        .quotient  (div_quot),
        .remainder (div_rem),
        .done      (div_done)
    );

    pita_emitter #(
        .VALUE_BITS (VALUE_BITS)
    ) u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .dig_wr    (dig_wr),
        .start     (emit_start),
        .lay       (layout_reg),
        .idle      (emit_idle),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .text_char (text_char),
        .last      (last),
        .bad_base  (bad_base)
    );

`ifndef SYNTH
    a_go_starts_emitter: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_GO) |=> !emit_idle)
        else $error("emitter did not start");

    a_extract_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_START) |-> emit_idle)
        else $error("digit extraction overlaps character output");

    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        dig_wr.we |-> (CNT_W'(dig_wr.addr) < CNT_W'(VALUE_BITS)))
        else $error("digit write beyond store");

    a_bad_radix_direct: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && bad_in) |=> (state_reg == T_GO))
        else $error("bad radix did not go straight to output");
`endif

endmodule
